// ===== rtl/wlac_pkg.sv =====
`default_nettype none

package wlac_pkg;

    localparam int LEVEL_BITS_DEF = 12;
    localparam int THR_BITS       = 12;
    localparam int INT_BITS       = 16;
    localparam int CFG_DATA_BITS  = 16;
    localparam int CFG_IDX_BITS   = 3;
    localparam int POT_BITS       = 10;
    localparam int ANGLE_BITS     = 8;
    localparam int CMD_BITS       = 2;

    localparam logic [ANGLE_BITS-1:0] MAX_ANGLE = 8'd180;
    localparam logic [POT_BITS-1:0]   POT_FULL  = 10'd1023;

    // 180 * ceil(2^28 / 1023), exact floor of 180 * pot / 1023 over the pot range
    localparam int                        POT_RECIP_BITS  = 26;
    localparam int                        POT_RECIP_SHIFT = 28;
    localparam logic [POT_RECIP_BITS-1:0] POT_ANGLE_RECIP = 26'd47232180;

    localparam logic [THR_BITS-1:0] ALARM_THR_RST    = 12'd200;
    localparam logic [THR_BITS-1:0] PREALARM_THR_RST = 12'd500;
    localparam logic [INT_BITS-1:0] INT_NORMAL_RST   = 16'd2000;
    localparam logic [INT_BITS-1:0] INT_PREALARM_RST = 16'd1000;
    localparam logic [INT_BITS-1:0] INT_ALARM_RST    = 16'd500;
    localparam int                  LEVEL_DRY        = 4095;

    localparam logic [CFG_IDX_BITS-1:0] REG_ALARM_THR    = 3'd0;
    localparam logic [CFG_IDX_BITS-1:0] REG_PREALARM_THR = 3'd1;
    localparam logic [CFG_IDX_BITS-1:0] REG_INT_NORMAL   = 3'd2;
    localparam logic [CFG_IDX_BITS-1:0] REG_INT_PREALARM = 3'd3;
    localparam logic [CFG_IDX_BITS-1:0] REG_INT_ALARM    = 3'd4;

    localparam logic [CMD_BITS-1:0] CMD_NONE   = 2'd0;
    localparam logic [CMD_BITS-1:0] CMD_MANUAL = 2'd1;
    localparam logic [CMD_BITS-1:0] CMD_AUTO   = 2'd2;
    localparam logic [CMD_BITS-1:0] CMD_ANGLE  = 2'd3;

    typedef enum logic [1:0] {
        LV_NORMAL = 2'd0,
        LV_PRE    = 2'd1,
        LV_ALARM  = 2'd2
    } t_level;

    typedef enum logic [1:0] {
        SM_AUTO   = 2'd0,
        SM_POT    = 2'd1,
        SM_SERIAL = 2'd2
    } t_submode;

    typedef enum logic [1:0] {
        S_IDLE   = 2'd0,
        S_LOAD   = 2'd1,
        S_DIV    = 2'd2,
        S_COMMIT = 2'd3
    } t_ctrl_state;

    typedef struct packed {
        logic accept;
        logic load;
        logic step;
        logic commit;
    } t_dp_cmd;

    typedef struct packed {
        logic need_div;
        logic div_done;
        logic out_free;
    } t_dp_sts;

endpackage

`default_nettype wire

// ===== rtl/wlac_ctrl.sv =====
`default_nettype none

module wlac_ctrl
    import wlac_pkg::*;
(
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    i_in_valid,
    output logic         o_in_stall,
    input  wire t_dp_sts i_sts,
    output t_dp_cmd      o_cmd
);

    t_ctrl_state r_state;
    t_ctrl_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_state = i_sts.need_div ? S_LOAD : S_COMMIT;
                end
            end
            S_LOAD: begin
                n_state = S_DIV;
            end
            S_DIV: begin
                if (i_sts.div_done) begin
                    n_state = S_COMMIT;
                end
            end
            S_COMMIT: begin
                if (i_sts.out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_comb begin
        o_in_stall    = (r_state != S_IDLE);
        o_cmd.accept  = (r_state == S_IDLE) && i_in_valid;
        o_cmd.load    = (r_state == S_LOAD);
        o_cmd.step    = (r_state == S_DIV);
        o_cmd.commit  = (r_state == S_COMMIT) && i_sts.out_free;
    end

endmodule

`default_nettype wire

// ===== rtl/wlac_dp.sv =====
`default_nettype none

module wlac_dp
    import wlac_pkg::*;
#(
    parameter int LEVEL_BITS = LEVEL_BITS_DEF
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    input  wire logic                     i_cfg_we,
    input  wire logic [CFG_IDX_BITS-1:0]  i_cfg_idx,
    input  wire logic [CFG_DATA_BITS-1:0] i_cfg_data,
    input  wire t_dp_cmd                  i_cmd,
    output t_dp_sts                       o_sts,
    input  wire logic [LEVEL_BITS-1:0]    i_distance,
    input  wire logic                     i_button_press,
    input  wire logic [POT_BITS-1:0]      i_pot_value,
    input  wire logic [CMD_BITS-1:0]      i_serial_cmd,
    input  wire logic [ANGLE_BITS-1:0]    i_serial_angle,
    output logic                          o_out_valid,
    input  wire logic                     i_out_stall,
    output logic [1:0]                    o_level_state,
    output logic [1:0]                    o_control_mode,
    output logic [ANGLE_BITS-1:0]         o_motor_angle,
    output logic                          o_motor_drive,
    output logic                          o_measured,
    output logic [LEVEL_BITS-1:0]         o_water_level,
    output logic                          o_green_led,
    output logic                          o_alarm_led_on,
    output logic                          o_alarm_led_blink,
    output logic                          o_backlight
);

    localparam int DW = LEVEL_BITS;
    localparam int NW = DW + ANGLE_BITS;
    localparam int CW = $clog2(NW);
    localparam int TW = (LEVEL_BITS > THR_BITS) ? LEVEL_BITS : THR_BITS;
    localparam int PW = POT_BITS + POT_RECIP_BITS;
    localparam logic [LEVEL_BITS-1:0] LEVEL_RST = LEVEL_BITS'(LEVEL_DRY);

    // configuration
    logic [THR_BITS-1:0] r_alarm_thr;
    logic [THR_BITS-1:0] r_pre_thr;
    logic [INT_BITS-1:0] r_int_normal;
    logic [INT_BITS-1:0] r_int_pre;
    logic [INT_BITS-1:0] r_int_alarm;

    // item payload
    logic                  r_button;
    logic [POT_BITS-1:0]   r_pot;
    logic [CMD_BITS-1:0]   r_cmd;
    logic [ANGLE_BITS-1:0] r_sang;
    logic                  r_measured;

    // block state
    t_level                r_level_mode;
    t_submode              r_submode;
    logic [LEVEL_BITS-1:0] r_stored_level;
    logic [ANGLE_BITS-1:0] r_angle;
    logic [INT_BITS-1:0]   r_countdown;

    // auto angle divider
    logic [NW-1:0] r_quo;
    logic [DW-1:0] r_rem;
    logic [DW-1:0] r_dvs;
    logic [CW-1:0] r_cnt;

    // output register
    logic                  r_out_valid;
    t_level                r_o_level;
    t_submode              r_o_submode;
    logic [ANGLE_BITS-1:0] r_o_angle;
    logic                  r_o_drive;
    logic                  r_o_measured;
    logic [LEVEL_BITS-1:0] r_o_level_val;

    logic [TW-1:0]         w_at_ext;
    logic [TW-1:0]         w_pt_ext;
    logic [LEVEL_BITS-1:0] w_at;
    logic [LEVEL_BITS-1:0] w_pt;
    logic [INT_BITS-1:0]   w_iv;
    logic [NW-1:0]         w_num;
    logic [DW-1:0]         w_dvs;
    logic [DW:0]           w_trial;
    logic [DW:0]           w_diff;
    logic                  w_ge;
    logic [ANGLE_BITS-1:0] w_auto_angle;
    logic [ANGLE_BITS-1:0] w_sat_angle;
    logic [PW-1:0]         w_pot_prod;
    logic [ANGLE_BITS-1:0] w_pot_angle;

    t_level                n_level_mode;
    t_submode              n_submode;
    logic [ANGLE_BITS-1:0] n_angle;
    logic                  n_drive;

    assign w_at_ext = TW'(r_alarm_thr);
    assign w_pt_ext = TW'(r_pre_thr);
    assign w_at     = w_at_ext[LEVEL_BITS-1:0];
    assign w_pt     = w_pt_ext[LEVEL_BITS-1:0];

    always_comb begin
        case (r_level_mode)
            LV_ALARM: w_iv = r_int_alarm;
            LV_PRE:   w_iv = r_int_pre;
            default:  w_iv = r_int_normal;
        endcase
    end

    // numerator and divisor for the auto angle
    assign w_num = NW'(r_stored_level) * NW'(MAX_ANGLE);
    assign w_dvs = w_at;

    assign w_trial = {r_rem, r_quo[NW-1]};
    assign w_diff  = w_trial - {1'b0, r_dvs};
    assign w_ge    = (w_trial >= {1'b0, r_dvs});

    assign w_auto_angle = ((w_at == '0) || (r_quo >= NW'(MAX_ANGLE))) ? '0
                        : MAX_ANGLE - r_quo[ANGLE_BITS-1:0];
    assign w_sat_angle  = (r_sang > MAX_ANGLE) ? MAX_ANGLE : r_sang;

    // pot angle by reciprocal multiplication
    assign w_pot_prod  = PW'(r_pot) * PW'(POT_ANGLE_RECIP);
    assign w_pot_angle = w_pot_prod[POT_RECIP_SHIFT +: ANGLE_BITS];

    always_comb begin
        n_level_mode = r_level_mode;
        n_submode    = r_submode;
        n_angle      = r_angle;
        n_drive      = 1'b0;
        case (r_level_mode)
            LV_NORMAL: begin
                if (r_stored_level < w_at) begin
                    n_level_mode = LV_ALARM;
                    n_submode    = SM_AUTO;
                end else if (r_stored_level < w_pt) begin
                    n_level_mode = LV_PRE;
                end
            end
            LV_PRE: begin
                if (r_stored_level < w_at) begin
                    n_level_mode = LV_ALARM;
                    n_submode    = SM_AUTO;
                end else if (r_stored_level > w_pt) begin
                    n_level_mode = LV_NORMAL;
                end
            end
            LV_ALARM: begin
                case (r_submode)
                    SM_AUTO: begin
                        if (r_button) begin
                            n_submode = SM_POT;
                        end else if (r_cmd == CMD_MANUAL) begin
                            n_submode = SM_SERIAL;
                        end
                        n_angle = w_auto_angle;
                    end
                    SM_POT: begin
                        if (r_button) begin
                            n_submode = SM_AUTO;
                        end
                        n_angle = w_pot_angle;
                    end
                    default: begin
                        if (r_cmd == CMD_AUTO) begin
                            n_submode = SM_AUTO;
                        end else if (r_cmd == CMD_ANGLE) begin
                            n_angle = w_sat_angle;
                        end
                    end
                endcase
                n_drive = 1'b1;
                if (r_stored_level > w_pt) begin
                    n_level_mode = LV_NORMAL;
                end else if (r_stored_level > w_at) begin
                    n_level_mode = LV_PRE;
                end
            end
            default: begin
                n_level_mode = r_level_mode;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_alarm_thr  <= ALARM_THR_RST;
            r_pre_thr    <= PREALARM_THR_RST;
            r_int_normal <= INT_NORMAL_RST;
            r_int_pre    <= INT_PREALARM_RST;
            r_int_alarm  <= INT_ALARM_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_ALARM_THR:    r_alarm_thr  <= i_cfg_data[THR_BITS-1:0];
                REG_PREALARM_THR: r_pre_thr    <= i_cfg_data[THR_BITS-1:0];
                REG_INT_NORMAL:   r_int_normal <= i_cfg_data[INT_BITS-1:0];
                REG_INT_PREALARM: r_int_pre    <= i_cfg_data[INT_BITS-1:0];
                REG_INT_ALARM:    r_int_alarm  <= i_cfg_data[INT_BITS-1:0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_level_mode   <= LV_NORMAL;
            r_submode      <= SM_AUTO;
            r_stored_level <= LEVEL_RST;
            r_angle        <= '0;
            r_countdown    <= '0;
        end else begin
            if (i_cmd.accept) begin
                if (r_countdown == '0) begin
                    r_stored_level <= i_distance;
                    r_countdown    <= (w_iv == '0) ? '0 : w_iv - 1'b1;
                end else begin
                    r_countdown <= r_countdown - 1'b1;
                end
            end
            if (i_cmd.commit) begin
                r_level_mode <= n_level_mode;
                r_submode    <= n_submode;
                r_angle      <= n_angle;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_button   <= i_button_press;
            r_pot      <= i_pot_value;
            r_cmd      <= i_serial_cmd;
            r_sang     <= i_serial_angle;
            r_measured <= (r_countdown == '0);
        end
    end

    // restoring divider, one quotient bit per cycle
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_quo <= w_num;
            r_rem <= '0;
            r_dvs <= w_dvs;
            r_cnt <= '0;
        end else if (i_cmd.step) begin
            r_quo <= {r_quo[NW-2:0], w_ge};
            r_rem <= w_ge ? w_diff[DW-1:0] : w_trial[DW-1:0];
            r_cnt <= r_cnt + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.commit) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.commit) begin
            r_o_level     <= n_level_mode;
            r_o_submode   <= n_submode;
            r_o_angle     <= n_angle;
            r_o_drive     <= n_drive;
            r_o_measured  <= r_measured;
            r_o_level_val <= r_stored_level;
        end
    end

    assign o_sts.need_div = (r_level_mode == LV_ALARM) && (r_submode == SM_AUTO);
    assign o_sts.div_done = (r_cnt == CW'(NW - 1));
    assign o_sts.out_free = !r_out_valid || !i_out_stall;

    assign o_out_valid       = r_out_valid;
    assign o_level_state     = r_o_level;
    assign o_control_mode    = r_o_submode;
    assign o_motor_angle     = r_o_angle;
    assign o_motor_drive     = r_o_drive;
    assign o_measured        = r_o_measured;
    assign o_water_level     = r_o_level_val;
    assign o_green_led       = (r_o_level != LV_ALARM);
    assign o_alarm_led_on    = (r_o_level == LV_ALARM);
    assign o_alarm_led_blink = (r_o_level == LV_PRE);
    assign o_backlight       = (r_o_level != LV_NORMAL);

endmodule

`default_nettype wire

// ===== rtl/water_level_alarm_controller_core.sv =====
// Water level alarm controller, one input item per millisecond tick.
// Input channel: i_in_valid / o_in_stall with distance, button, pot, serial
// command and serial angle. Output channel: o_out_valid / i_out_stall with
// state, sub-mode, servo angle, measurement flag, latched level and LEDs.
// Configuration: i_cfg_we writes i_cfg_data into register i_cfg_idx
// (0 alarm threshold, 1 pre-alarm threshold, 2..4 measuring intervals).
// Flow: an item that needs no angle division passes from acceptance through
// the commit state into the output register, and the next item is taken
// once the controller is back in idle. In alarm with auto sub-mode the item
// passes through load, the restoring divider (one quotient bit a cycle) and
// commit. The pot angle uses a multiplier and no division.
// Reset (synchronous, active low) sets the normal state, auto sub-mode,
// level 4095, angle 0 and a zero countdown, so the first item measures.
// Results sit in an output register; while one waits the block takes one
// more item, then holds its result and stalls the input until the receiver
// takes the waiting result.
`default_nettype none

module water_level_alarm_controller_core
    import wlac_pkg::*;
#(
    parameter int LEVEL_BITS = LEVEL_BITS_DEF
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    input  wire logic                     i_cfg_we,
    input  wire logic [CFG_IDX_BITS-1:0]  i_cfg_idx,
    input  wire logic [CFG_DATA_BITS-1:0] i_cfg_data,
    input  wire logic                     i_in_valid,
    output logic                          o_in_stall,
    input  wire logic [LEVEL_BITS-1:0]    i_distance,
    input  wire logic                     i_button_press,
    input  wire logic [POT_BITS-1:0]      i_pot_value,
    input  wire logic [CMD_BITS-1:0]      i_serial_cmd,
    input  wire logic [ANGLE_BITS-1:0]    i_serial_angle,
    output logic                          o_out_valid,
    input  wire logic                     i_out_stall,
    output logic [1:0]                    o_level_state,
    output logic [1:0]                    o_control_mode,
    output logic [ANGLE_BITS-1:0]         o_motor_angle,
    output logic                          o_motor_drive,
    output logic                          o_measured,
    output logic [LEVEL_BITS-1:0]         o_water_level,
    output logic                          o_green_led,
    output logic                          o_alarm_led_on,
    output logic                          o_alarm_led_blink,
    output logic                          o_backlight
);

    t_dp_cmd w_cmd;
    t_dp_sts w_sts;

    wlac_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_sts      (w_sts),
        .o_cmd      (w_cmd)
    );

    wlac_dp #(
        .LEVEL_BITS (LEVEL_BITS)
    ) u_dp (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cfg_we          (i_cfg_we),
        .i_cfg_idx         (i_cfg_idx),
        .i_cfg_data        (i_cfg_data),
        .i_cmd             (w_cmd),
        .o_sts             (w_sts),
        .i_distance        (i_distance),
        .i_button_press    (i_button_press),
        .i_pot_value       (i_pot_value),
        .i_serial_cmd      (i_serial_cmd),
        .i_serial_angle    (i_serial_angle),
        .o_out_valid       (o_out_valid),
        .i_out_stall       (i_out_stall),
        .o_level_state     (o_level_state),
        .o_control_mode    (o_control_mode),
        .o_motor_angle     (o_motor_angle),
        .o_motor_drive     (o_motor_drive),
        .o_measured        (o_measured),
        .o_water_level     (o_water_level),
        .o_green_led       (o_green_led),
        .o_alarm_led_on    (o_alarm_led_on),
        .o_alarm_led_blink (o_alarm_led_blink),
        .o_backlight       (o_backlight)
    );

endmodule

`default_nettype wire
